[rtl/vre_pkg.sv]
// shared types and constants for the vector rate estimator
package vre_pkg;

    localparam int AXES   = 3;
    localparam int AXW    = (AXES > 1) ? $clog2(AXES) : 1;
    localparam int VW     = 32;
    localparam int PW     = 24;
    localparam int CW     = 24;
    localparam int MW     = VW + 1;
    localparam int NUMW   = MW + 20;
    localparam int RW     = 58;
    localparam int QW     = (NUMW > 32) ? NUMW : 32;
    localparam int STEPW  = $clog2(QW + 1);
    localparam int ALW    = 32;
    localparam int CMPW   = (NUMW > 64) ? NUMW : 64;

    localparam logic [19:0]     US_PER_S  = 20'd1000000;
    localparam logic [33:0]     TAU_SCALE = 34'd10430378350;
    localparam logic [63:0]     MAG_LIMIT = 64'd9000000000000;
    // floor(mag/period) > limit  <=>  floor(mag*1e6/period) >= (limit+1)*1e6
    localparam logic [63:0]     SAT_QUOT  = 64'd9000000000001000000;

    typedef enum logic {
        REQ_SAMPLE  = 1'b0,
        REQ_RESTART = 1'b1
    } t_req;

    typedef enum logic [1:0] {
        CFG_CUTOFF_X = 2'd0,
        CFG_CUTOFF_Y = 2'd1,
        CFG_CUTOFF_Z = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic                 req_type;
        logic signed [VW-1:0] value_x;
        logic signed [VW-1:0] value_y;
        logic signed [VW-1:0] value_z;
        logic [PW-1:0]        period_us;
    } t_in_beat;

    typedef struct packed {
        logic signed [VW-1:0] rate_x;
        logic signed [VW-1:0] rate_y;
        logic signed [VW-1:0] rate_z;
    } t_out_beat;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_RGO,
        S_RDIV,
        S_FILT,
        S_ADIV,
        S_MUL,
        S_UPD,
        S_NEXT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load_in;
        logic clear_hist;
        logic store_prev;
        logic zero_res;
        logic rdiv_start;
        logic raw_latch;
        logic res_raw;
        logic prime;
        logic adiv_start;
        logic filt_mul;
        logic filt_upd;
        logic axis_next;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic restart;
        logic period_zero;
        logic have_prev;
        logic div_busy;
        logic cutoff_zero;
        logic primed;
        logic last_axis;
        logic out_full;
    } t_stat;

endpackage

[rtl/vector_rate_estimator.sv]
// Three-axis rate estimator: per-axis finite difference with a first-order low-pass.
// Input channel (i_in_valid / o_in_ready) carries a request type, three signed Q16.16
// values and a period in microseconds; output channel (o_out_valid / i_out_ready)
// returns one beat with three Q16.16 rates per input beat, in order.
// Cutoffs are written through i_cfg_we / i_cfg_idx / i_cfg_data; the user must write
// them only while idle, as the block does not enforce it. Restart, zero period and
// the first sample after reset or restart skip the divider and return zero rates. A
// full sample runs each axis through one shared radix-2 divider, for the 53-bit rate
// quotient and, when the filter is active, the 32-bit alpha; one beat is worked on
// at a time.
// Results sit in an output register; the next input beat is taken once the
// current one has been handed to that register, so a stalled receiver holds at
// most one finished beat while a new one is computed, then back-pressures.
// Synchronous active-low reset clears history, filter state and cutoffs.
module vector_rate_estimator (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  vre_pkg::t_in_beat  i_in_beat,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output vre_pkg::t_out_beat o_out_beat,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [23:0]        i_cfg_data
);
    import vre_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    vre_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    vre_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_in_beat   (i_in_beat),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_beat  (o_out_beat)
    );
endmodule

[rtl/vre_div.sv]
// shared radix-2 restoring divider, one quotient bit per cycle
module vre_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [vre_pkg::RW-1:0]    i_rem_init,
    input  logic [vre_pkg::QW-1:0]    i_dvd_init,
    input  logic [vre_pkg::RW-1:0]    i_divisor,
    input  logic [vre_pkg::STEPW-1:0] i_steps,
    output logic                      o_busy,
    output logic [vre_pkg::QW-1:0]    o_quot
);
    import vre_pkg::*;

    logic [RW-1:0]    r_rem, n_rem;
    logic [QW-1:0]    r_quo, n_quo;
    logic [RW-1:0]    r_dvs;
    logic [STEPW-1:0] r_cnt, n_cnt;
    logic             r_busy, n_busy;
    logic [RW-1:0]    w_trial;
    logic             w_fit;

    assign w_trial = {r_rem[RW-2:0], r_quo[QW-1]};
    assign w_fit   = (w_trial >= r_dvs);

    always_comb begin
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        if (i_start) begin
            n_rem  = i_rem_init;
            n_quo  = i_dvd_init;
            n_cnt  = i_steps;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_rem  = w_fit ? (w_trial - r_dvs) : w_trial;
            n_quo  = {r_quo[QW-2:0], w_fit};
            n_cnt  = r_cnt - STEPW'(1);
            n_busy = (r_cnt != STEPW'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_cnt <= n_cnt;
        if (i_start) begin
            r_dvs <= i_divisor;
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_quo;
endmodule

[rtl/vre_dp.sv]
// datapath: history, filter state, rate and alpha arithmetic, result register
module vre_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  vre_pkg::t_cmd      i_cmd,
    output vre_pkg::t_stat     o_stat,
    input  vre_pkg::t_in_beat  i_in_beat,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [23:0]        i_cfg_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output vre_pkg::t_out_beat o_out_beat
);
    import vre_pkg::*;

    t_in_beat             r_in;
    logic [CW-1:0]        r_cutoff [AXES];
    logic signed [VW-1:0] r_prev   [AXES];
    logic signed [VW-1:0] r_fv     [AXES];
    logic [AXES-1:0]      r_primed;
    logic                 r_have_prev;
    logic [AXW-1:0]       r_axis;
    logic signed [VW-1:0] r_raw;
    logic signed [VW-1:0] r_res    [AXES];
    logic                 r_neg;
    logic [MW+ALW-1:0]    r_prod;
    logic                 r_fneg;
    logic                 r_out_valid;
    t_out_beat            r_out;

    logic signed [VW-1:0] w_cur [AXES];
    logic signed [VW-1:0] w_cur_sel;
    logic signed [MW-1:0] w_diff;
    logic [MW-1:0]        w_mag;
    logic [NUMW-1:0]      w_num;
    logic [2*CW+7:0]      w_a;
    logic [RW-1:0]        w_b;
    logic                 w_busy;
    logic [QW-1:0]        w_quot;
    logic                 w_div_start;
    logic [RW-1:0]        w_rem_init;
    logic [QW-1:0]        w_dvd_init;
    logic [RW-1:0]        w_divisor;
    logic [STEPW-1:0]     w_steps;
    logic [CMPW-1:0]      w_q_ext;
    logic [CMPW-1:0]      w_mag_res;
    logic signed [VW-1:0] w_sat;
    logic signed [MW-1:0] w_fdiff;
    logic [MW-1:0]        w_fmag;
    logic [MW-1:0]        w_delta;
    logic signed [MW-1:0] w_fnew;

    assign w_cur[0] = r_in.value_x;
    assign w_cur[1] = r_in.value_y;
    assign w_cur[2] = r_in.value_z;

    assign w_cur_sel = w_cur[r_axis];
    assign w_diff    = MW'(w_cur_sel) - MW'(r_prev[r_axis]);
    assign w_mag     = w_diff[MW-1] ? (MW'(0) - w_diff) : w_diff;
    assign w_num     = NUMW'(w_mag) * NUMW'(US_PER_S);

    // alpha = floor(2^32 * A / (A + tau)), A = cutoff * period * 256
    assign w_a = {(2*CW)'(r_cutoff[r_axis]) * (2*CW)'(r_in.period_us), 8'd0};
    assign w_b = RW'(w_a) + RW'(TAU_SCALE);

    assign w_div_start = i_cmd.rdiv_start | i_cmd.adiv_start;
    assign w_rem_init  = i_cmd.adiv_start ? RW'(w_a) : '0;
    assign w_dvd_init  = i_cmd.adiv_start ? '0 : QW'(w_num);
    assign w_divisor   = i_cmd.adiv_start ? w_b : RW'(r_in.period_us);
    assign w_steps     = i_cmd.adiv_start ? STEPW'(ALW) : STEPW'(NUMW);

    vre_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_rem_init (w_rem_init),
        .i_dvd_init (w_dvd_init),
        .i_divisor  (w_divisor),
        .i_steps    (w_steps),
        .o_busy     (w_busy),
        .o_quot     (w_quot)
    );

    // raw rate clamp, then saturate to the value width
    assign w_q_ext   = CMPW'(w_quot[NUMW-1:0]);
    assign w_mag_res = (w_q_ext >= CMPW'(SAT_QUOT)) ? CMPW'(MAG_LIMIT) : w_q_ext;

    always_comb begin
        if (r_neg) begin
            if (w_mag_res >= (CMPW'(1) << (VW-1))) begin
                w_sat = {1'b1, {(VW-1){1'b0}}};
            end else begin
                w_sat = VW'(CMPW'(0) - w_mag_res);
            end
        end else begin
            if (w_mag_res >= (CMPW'(1) << (VW-1))) begin
                w_sat = {1'b0, {(VW-1){1'b1}}};
            end else begin
                w_sat = VW'(w_mag_res);
            end
        end
    end

    assign w_fdiff = MW'(r_raw) - MW'(r_fv[r_axis]);
    assign w_fmag  = w_fdiff[MW-1] ? (MW'(0) - w_fdiff) : w_fdiff;
    assign w_delta = r_prod[MW+ALW-1:ALW];
    assign w_fnew  = r_fneg ? (MW'(r_fv[r_axis]) - w_delta) : (MW'(r_fv[r_axis]) + w_delta);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < AXES; a++) begin
                r_cutoff[a] <= '0;
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CUTOFF_X: r_cutoff[0] <= i_cfg_data[CW-1:0];
                CFG_CUTOFF_Y: r_cutoff[1] <= i_cfg_data[CW-1:0];
                CFG_CUTOFF_Z: r_cutoff[2] <= i_cfg_data[CW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_prev <= 1'b0;
            r_primed    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clear_hist) begin
                r_have_prev <= 1'b0;
                r_primed    <= '0;
            end
            if (i_cmd.store_prev) begin
                r_have_prev <= 1'b1;
            end
            if (i_cmd.prime) begin
                r_primed[r_axis] <= 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_in   <= i_in_beat;
            r_axis <= '0;
        end else if (i_cmd.axis_next) begin
            r_axis <= r_axis + AXW'(1);
        end
        if (i_cmd.store_prev) begin
            for (int a = 0; a < AXES; a++) begin
                r_prev[a] <= w_cur[a];
            end
        end
        if (i_cmd.zero_res) begin
            for (int a = 0; a < AXES; a++) begin
                r_res[a] <= '0;
            end
        end
        if (i_cmd.rdiv_start) begin
            r_neg <= w_diff[MW-1];
        end
        if (i_cmd.raw_latch) begin
            r_raw          <= w_sat;
            r_prev[r_axis] <= w_cur_sel;
        end
        if (i_cmd.res_raw) begin
            r_res[r_axis] <= r_raw;
        end
        if (i_cmd.prime) begin
            r_fv[r_axis] <= r_raw;
        end
        if (i_cmd.filt_mul) begin
            r_prod <= (MW+ALW)'(w_fmag) * (MW+ALW)'(w_quot[ALW-1:0]);
            r_fneg <= w_fdiff[MW-1];
        end
        if (i_cmd.filt_upd) begin
            r_fv[r_axis]  <= w_fnew[VW-1:0];
            r_res[r_axis] <= w_fnew[VW-1:0];
        end
        if (i_cmd.out_load) begin
            r_out.rate_x <= r_res[0];
            r_out.rate_y <= r_res[1];
            r_out.rate_z <= r_res[2];
        end
    end

    assign o_stat.restart     = (r_in.req_type == REQ_RESTART);
    assign o_stat.period_zero = (r_in.period_us == '0);
    assign o_stat.have_prev   = r_have_prev;
    assign o_stat.div_busy    = w_busy;
    assign o_stat.cutoff_zero = (r_cutoff[r_axis] == '0);
    assign o_stat.primed      = r_primed[r_axis];
    assign o_stat.last_axis   = (r_axis == AXW'(AXES - 1));
    assign o_stat.out_full    = r_out_valid;

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

`ifndef SYNTH
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> !r_out_valid)
        else $error("result overwritten while waiting");
    a_div_idle_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |-> !w_busy)
        else $error("divider restarted while busy");
    a_restart_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clear_hist |=> (!r_have_prev && (r_primed == '0)))
        else $error("restart left history");
`endif
endmodule

[rtl/vre_ctrl.sv]
// sequencer: walks each item through decode, rate divide and filter per axis
module vre_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  vre_pkg::t_stat i_stat,
    output vre_pkg::t_cmd  o_cmd
);
    import vre_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_in_valid) n_state = S_DECIDE;
            S_DECIDE: begin
                if (i_stat.restart || i_stat.period_zero || !i_stat.have_prev) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_RGO;
                end
            end
            S_RGO:    n_state = S_RDIV;
            S_RDIV:   if (!i_stat.div_busy) n_state = S_FILT;
            S_FILT: begin
                if (i_stat.cutoff_zero || !i_stat.primed) begin
                    n_state = S_NEXT;
                end else begin
                    n_state = S_ADIV;
                end
            end
            S_ADIV:   if (!i_stat.div_busy) n_state = S_MUL;
            S_MUL:    n_state = S_UPD;
            S_UPD:    n_state = S_NEXT;
            S_NEXT:   n_state = i_stat.last_axis ? S_DONE : S_RGO;
            S_DONE:   if (!i_stat.out_full) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.load_in = i_in_valid;
            end
            S_DECIDE: begin
                if (i_stat.restart) begin
                    o_cmd.clear_hist = 1'b1;
                    o_cmd.zero_res   = 1'b1;
                end else if (i_stat.period_zero) begin
                    o_cmd.zero_res = 1'b1;
                end else if (!i_stat.have_prev) begin
                    o_cmd.store_prev = 1'b1;
                    o_cmd.zero_res   = 1'b1;
                end
            end
            S_RGO:  o_cmd.rdiv_start = 1'b1;
            S_RDIV: o_cmd.raw_latch  = !i_stat.div_busy;
            S_FILT: begin
                if (i_stat.cutoff_zero) begin
                    o_cmd.res_raw = 1'b1;
                end else if (!i_stat.primed) begin
                    o_cmd.res_raw = 1'b1;
                    o_cmd.prime   = 1'b1;
                end else begin
                    o_cmd.adiv_start = 1'b1;
                end
            end
            S_ADIV: ;
            S_MUL:  o_cmd.filt_mul  = 1'b1;
            S_UPD:  o_cmd.filt_upd  = 1'b1;
            S_NEXT: o_cmd.axis_next = !i_stat.last_axis;
            S_DONE: o_cmd.out_load  = !i_stat.out_full;
            default: ;
        endcase
    end
endmodule

[bench/vector_rate_estimator_tb.sv]
// self-checking testbench for the vector rate estimator
module vector_rate_estimator_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import vre_pkg::*;

    localparam int TIMEOUT_CYCLES = 20000;
    localparam longint TAU = 64'd10430378350;
    localparam longint RATE_CAP = 64'd9000000000000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    t_in_beat i_in_beat = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_out_beat o_out_beat;
    logic i_cfg_we = 1'b0;
    logic [1:0] i_cfg_idx = '0;
    logic [23:0] i_cfg_data = '0;

    always #4 i_clk = ~i_clk;

    vector_rate_estimator dut (.*);

    // predictor state
    logic [23:0] cut_r [AXES];
    longint prev_val [AXES];
    bit have_prev;
    longint filt_val [AXES];
    bit filt_primed [AXES];

    t_out_beat rate_q [$];
    int errors = 0;
    int hold_cycles = 0;
    bit no_idle = 1'b0;
    int stall_cycles = 0;

    function automatic longint sat_w(bit neg, longint unsigned mag);
        if (neg) return (mag >= 64'h80000000) ? -64'sh80000000 : -longint'(mag);
        return (mag >= 64'h80000000) ? 64'sh7fffffff : longint'(mag);
    endfunction

    function automatic longint raw_rate_of(longint cur, longint prv, int unsigned per);
        longint d;
        bit neg;
        longint unsigned mag, q, r, res;
        d = cur - prv;
        neg = d < 0;
        mag = neg ? -d : d;
        q = mag / per;
        r = mag % per;
        if (q > RATE_CAP) res = RATE_CAP;
        else res = q * 64'd1000000 + (r * 64'd1000000) / per;
        return sat_w(neg, res);
    endfunction

    function automatic longint unsigned alpha_of(logic [23:0] c, int unsigned per);
        longint unsigned a, b, rem, q;
        a = (longint'(c) * per) << 8;
        b = a + TAU;
        rem = a;
        q = 0;
        for (int i = 0; i < 32; i++) begin
            rem = rem << 1;
            q = q << 1;
            if (rem >= b) begin
                rem = rem - b;
                q = q | 1;
            end
        end
        return q;
    endfunction

    function automatic longint lowpass(int ax, longint x, int unsigned per);
        longint unsigned al, mag, dl;
        longint d;
        bit neg;
        if (cut_r[ax] == 0) return x;
        if (!filt_primed[ax]) begin
            filt_val[ax] = x;
            filt_primed[ax] = 1'b1;
            return x;
        end
        al = alpha_of(cut_r[ax], per);
        d = x - filt_val[ax];
        neg = d < 0;
        mag = neg ? -d : d;
        dl = (mag >> 32) * al + (((mag & 64'hffffffff) * al) >> 32);
        filt_val[ax] = neg ? filt_val[ax] - longint'(dl) : filt_val[ax] + longint'(dl);
        return filt_val[ax];
    endfunction

    function automatic void clear_hist();
        for (int a = 0; a < AXES; a++) begin
            prev_val[a] = 0;
            filt_val[a] = 0;
            filt_primed[a] = 1'b0;
        end
        have_prev = 1'b0;
    endfunction

    function automatic t_out_beat predict_rates(t_in_beat b);
        t_out_beat o;
        longint v [AXES];
        longint r [AXES];
        int unsigned per;
        o = '0;
        per = b.period_us;
        v[0] = longint'(b.value_x);
        v[1] = longint'(b.value_y);
        v[2] = longint'(b.value_z);
        if (b.req_type == REQ_RESTART) begin
            clear_hist();
            return o;
        end
        if (per == 0) return o;
        if (!have_prev) begin
            for (int a = 0; a < AXES; a++) prev_val[a] = v[a];
            have_prev = 1'b1;
            return o;
        end
        for (int a = 0; a < AXES; a++) begin
            r[a] = lowpass(a, raw_rate_of(v[a], prev_val[a], per), per);
            prev_val[a] = v[a];
        end
        o.rate_x = r[0][31:0];
        o.rate_y = r[1][31:0];
        o.rate_z = r[2][31:0];
        return o;
    endfunction

    // receiver: random stalls, plus one long hold-off on request
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_out_ready <= 1'b0;
        end else if (stall_cycles > 0) begin
            stall_cycles <= stall_cycles - 1;
            i_out_ready <= 1'b0;
        end else if (!no_idle && $urandom_range(0, 9) == 0) begin
            stall_cycles <= $urandom_range(1, 9);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_out_beat exp_b;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (rate_q.size() == 0) begin
                $error("result beat with nothing expected");
                errors++;
            end else begin
                exp_b = rate_q.pop_front();
                if (o_out_beat.rate_x !== exp_b.rate_x) begin
                    $error("rate_x exp %0d got %0d", exp_b.rate_x, o_out_beat.rate_x);
                    errors++;
                end
                if (o_out_beat.rate_y !== exp_b.rate_y) begin
                    $error("rate_y exp %0d got %0d", exp_b.rate_y, o_out_beat.rate_y);
                    errors++;
                end
                if (o_out_beat.rate_z !== exp_b.rate_z) begin
                    $error("rate_z exp %0d got %0d", exp_b.rate_z, o_out_beat.rate_z);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles without any beat
    int quiet_cycles = 0;
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= TIMEOUT_CYCLES) begin
            $display("vector_rate_estimator_tb: done, errors");
            $finish;
        end
    end

    task automatic write_cutoff(t_cfg_idx idx, logic [23:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        cut_r[idx] = val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // stop offering beats
    task automatic drop_valid();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        drop_valid();
        while (rate_q.size() != 0) @(negedge i_clk);
        repeat (300) @(negedge i_clk);
    endtask

    // send one beat; the expectation is queued when the beat is taken
    task automatic send_beat(t_in_beat b, bit gaps);
        @(negedge i_clk);
        if (gaps && !no_idle && $urandom_range(0, 7) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_beat <= b;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        rate_q.push_back(predict_rates(b));
    endtask

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 5))
            0: return 32'h80000000;
            1: return 32'h7fffffff;
            2: return $urandom_range(0, 2000) - 1000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [23:0] rand_period();
        case ($urandom_range(0, 9))
            0: return 24'd0;
            1: return 24'hffffff;
            2: return 24'd1;
            3: return 24'($urandom);
            default: return 24'($urandom_range(100, 20000));
        endcase
    endfunction

    function automatic t_in_beat rand_beat();
        t_in_beat b;
        b.req_type = ($urandom_range(0, 39) == 0) ? REQ_RESTART : REQ_SAMPLE;
        b.value_x = rand_value();
        b.value_y = rand_value();
        b.value_z = rand_value();
        b.period_us = rand_period();
        return b;
    endfunction

    typedef struct {
        t_in_beat beat;
        bit       typed;
        t_out_beat want;
    } t_row;

    t_row dir_rows [$];

    function automatic t_row mk_row(t_req rq, logic [31:0] x, logic [31:0] y,
                                    logic [31:0] z, logic [23:0] p, bit typed,
                                    t_out_beat w);
        t_row r;
        r.beat.req_type = rq;
        r.beat.value_x = x;
        r.beat.value_y = y;
        r.beat.value_z = z;
        r.beat.period_us = p;
        r.typed = typed;
        r.want = w;
        return r;
    endfunction

    initial begin
        t_out_beat zero_b;
        t_out_beat sat_b;
        t_out_beat exp_b;
        zero_b = '0;
        sat_b.rate_x = 32'h7fffffff;
        sat_b.rate_y = 32'h80000000;
        sat_b.rate_z = 32'h00000000;
        for (int a = 0; a < AXES; a++) cut_r[a] = '0;
        clear_hist();

        // zero period, first sample, saturation, restart, extremes
        dir_rows.push_back(mk_row(REQ_SAMPLE, 32'd5, 32'd6, 32'd7, 24'd0, 1, zero_b));
        dir_rows.push_back(mk_row(REQ_SAMPLE, 32'h80000000, 32'h7fffffff, 32'd0,
                                  24'd1, 1, zero_b));
        dir_rows.push_back(mk_row(REQ_SAMPLE, 32'h7fffffff, 32'h80000000, 32'd0,
                                  24'd1, 1, sat_b));
        dir_rows.push_back(mk_row(REQ_SAMPLE, 32'd100, 32'd200, 32'd300,
                                  24'hffffff, 0, zero_b));
        dir_rows.push_back(mk_row(REQ_SAMPLE, 32'd1100, 32'd0, 32'hffffffff,
                                  24'd1000, 0, zero_b));
        dir_rows.push_back(mk_row(REQ_RESTART, 32'hffffffff, 32'hffffffff, 32'hffffffff,
                                  24'hffffff, 1, zero_b));
        dir_rows.push_back(mk_row(REQ_SAMPLE, 32'd9, 32'd9, 32'd9, 24'd50, 1, zero_b));
        dir_rows.push_back(mk_row(REQ_SAMPLE, 32'd65536, 32'hffff0000, 32'd9,
                                  24'd1000, 0, zero_b));

        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[i]) begin
            exp_b = predict_rates(dir_rows[i].beat);
            if (dir_rows[i].typed && exp_b !== dir_rows[i].want) begin
                $error("table row %0d disagrees with predictor", i);
                errors++;
            end
        end
        // rerun predictor from reset for the real pass
        clear_hist();
        foreach (dir_rows[i]) send_beat(dir_rows[i].beat, 0);
        wait_drained();

        // filter on: priming, then filtering with extreme cutoffs
        write_cutoff(CFG_CUTOFF_X, 24'd1);
        write_cutoff(CFG_CUTOFF_Y, 24'hffffff);
        write_cutoff(CFG_CUTOFF_Z, 24'd2560);
        for (int i = 0; i < 6; i++) send_beat(rand_beat(), 0);
        wait_drained();

        for (int ph = 0; ph < 6; ph++) begin
            write_cutoff(CFG_CUTOFF_X, (ph % 3 == 0) ? 24'd0 : 24'($urandom));
            write_cutoff(CFG_CUTOFF_Y, (ph == 1) ? 24'hffffff : 24'($urandom_range(0, 5000)));
            write_cutoff(CFG_CUTOFF_Z, (ph == 2) ? 24'd0 : 24'($urandom_range(1, 100000)));
            if (ph == 2) hold_cycles = 2000;
            if (ph == 5) no_idle = 1'b1;
            for (int i = 0; i < 240; i++) begin
                // one pause in this phase until everything is back
                if (ph == 3 && i == 100) begin
                    drop_valid();
                    while (rate_q.size() != 0) @(negedge i_clk);
                end
                send_beat(rand_beat(), 1);
            end
            wait_drained();
        end

        if (errors == 0)
            $display("vector_rate_estimator_tb: done, clean");
        else
            $display("vector_rate_estimator_tb: done, errors");
        $finish;
    end
endmodule
